FILE: rtl/rvc_pkg.sv
// ----------------------------------------------------------------------------
// rvc_pkg
// Shared types and codes for the relay voltage cutoff / periodic controller.
// ----------------------------------------------------------------------------
package rvc_pkg;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 32;

  typedef enum logic [1:0] {
    CMD_UPDATE  = 2'd0,
    CMD_SET     = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_EXPIRED = 2'd1,
    EV_RESTORE = 2'd2,
    EV_CUTOFF  = 2'd3
  } event_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_MIN_MV       = 3'd0,
    REG_RESTORE_MV   = 3'd1,
    REG_DEBOUNCE_MS  = 3'd2,
    REG_ON_MS        = 3'd3,
    REG_OFF_MS       = 3'd4,
    REG_CUTOFF_EN    = 3'd5,
    REG_PERIODIC_EN  = 3'd6,
    REG_IGNORE_LOW_V = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] now_ms;
    logic [15:0] supply_mv;
    logic        manual_on;
    logic [31:0] manual_timeout_ms;
  } req_t;

  typedef struct packed {
    logic        relay_on;
    logic        override_active;
    logic [1:0]  event_code;
    logic [15:0] event_millivolts;
  } rsp_t;

  typedef struct packed {
    logic [15:0] min_millivolts;
    logic [15:0] restore_millivolts;
    logic [31:0] debounce_time_ms;
    logic [31:0] on_time_ms;
    logic [31:0] off_time_ms;
    logic        cutoff_enable;
    logic        periodic_enable;
    logic        ignore_low_voltage;
  } cfg_t;

  // wrap-safe check of a start stamp against the current time
  function automatic logic timer_done(logic [31:0] now, logic [31:0] start,
                                      logic [31:0] len);
    logic [31:0] elapsed;
    elapsed = now - start;
    return elapsed >= len;
  endfunction

endpackage

FILE: rtl/rvc_cfg.sv
// ----------------------------------------------------------------------------
// rvc_cfg
// Configuration register file, written through a simple indexed port.
// ----------------------------------------------------------------------------
module rvc_cfg import rvc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data,
  output cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_millivolts     <= 16'd0;
      cfg.restore_millivolts <= 16'hFFFF;
      cfg.debounce_time_ms   <= 32'd0;
      cfg.on_time_ms         <= 32'd0;
      cfg.off_time_ms        <= 32'd0;
      cfg.cutoff_enable      <= 1'b0;
      cfg.periodic_enable    <= 1'b0;
      cfg.ignore_low_voltage <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_MIN_MV:       cfg.min_millivolts     <= cfg_data[15:0];
        REG_RESTORE_MV:   cfg.restore_millivolts <= cfg_data[15:0];
        REG_DEBOUNCE_MS:  cfg.debounce_time_ms   <= cfg_data;
        REG_ON_MS:        cfg.on_time_ms         <= cfg_data;
        REG_OFF_MS:       cfg.off_time_ms        <= cfg_data;
        REG_CUTOFF_EN:    cfg.cutoff_enable      <= cfg_data[0];
        REG_PERIODIC_EN:  cfg.periodic_enable    <= cfg_data[0];
        REG_IGNORE_LOW_V: cfg.ignore_low_voltage <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/rvc_engine.sv
// ----------------------------------------------------------------------------
// rvc_engine
// Controller state and the single-pass update for one item: override timer,
// debounced voltage window rule, periodic cycle and rule combination.
// ----------------------------------------------------------------------------
module rvc_engine import rvc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic go,
  input  req_t req,
  input  cfg_t cfg,
  output rsp_t rsp
);

  logic        relay_state,     relay_state_next;
  logic        override_flag,   override_flag_next;
  logic [31:0] override_length, override_length_next;
  logic [31:0] override_start,  override_start_next;
  logic        pending_valid,   pending_valid_next;
  logic        pending_target,  pending_target_next;
  logic [31:0] debounce_start,  debounce_start_next;
  logic        cycle_started,   cycle_started_next;
  logic        cycle_phase_on,  cycle_phase_on_next;
  logic [31:0] cycle_start,     cycle_start_next;

  logic        run;
  logic        want;
  logic        cut_rule;
  logic        per_rule;
  logic [31:0] phase_len;
  event_t      ev;
  logic [15:0] ev_mv;

  assign phase_len = cycle_phase_on ? cfg.on_time_ms : cfg.off_time_ms;
  assign want = (req.supply_mv >= cfg.min_millivolts) &&
                (req.supply_mv <= cfg.restore_millivolts);

  always_comb begin
    relay_state_next     = relay_state;
    override_flag_next   = override_flag;
    override_length_next = override_length;
    override_start_next  = override_start;
    pending_valid_next   = pending_valid;
    pending_target_next  = pending_target;
    debounce_start_next  = debounce_start;
    cycle_started_next   = cycle_started;
    cycle_phase_on_next  = cycle_phase_on;
    cycle_start_next     = cycle_start;
    run      = 1'b0;
    ev       = EV_NONE;
    ev_mv    = 16'd0;
    cut_rule = relay_state;
    per_rule = relay_state;

    unique case (cmd_t'(req.command))
      CMD_UPDATE: begin
        run = 1'b1;
        if (override_flag) begin
          if (override_length != 32'd0 &&
              timer_done(req.now_ms, override_start, override_length)) begin
            override_flag_next   = 1'b0;
            override_length_next = 32'd0;
            ev                   = EV_EXPIRED;
          end else begin
            run = 1'b0;
          end
        end
      end
      CMD_SET: begin
        relay_state_next     = req.manual_on;
        override_flag_next   = 1'b1;
        override_length_next = req.manual_timeout_ms;
        if (req.manual_timeout_ms != 32'd0) override_start_next = req.now_ms;
      end
      CMD_RELEASE: begin
        override_flag_next   = 1'b0;
        override_length_next = 32'd0;
      end
      default: ;  // unused code: no change
    endcase

    if (run) begin
      // voltage window, debounced
      if (!cfg.cutoff_enable) begin
        pending_valid_next = 1'b0;
      end else if (req.supply_mv != 16'd0) begin
        if (want == relay_state) begin
          pending_valid_next = 1'b0;
        end else if (!pending_valid || pending_target != want) begin
          pending_valid_next  = 1'b1;
          pending_target_next = want;
          debounce_start_next = req.now_ms;
        end else if (timer_done(req.now_ms, debounce_start,
                                cfg.debounce_time_ms)) begin
          pending_valid_next = 1'b0;
          if (want) begin
            ev = EV_RESTORE;
          end else begin
            ev = EV_CUTOFF;
          end
          ev_mv    = req.supply_mv;
          cut_rule = want;
        end
      end

      // periodic on/off cycle
      if (cfg.periodic_enable) begin
        if (!cycle_started) begin
          cycle_started_next  = 1'b1;
          cycle_phase_on_next = 1'b1;
          cycle_start_next    = req.now_ms;
        end else if (timer_done(req.now_ms, cycle_start, phase_len)) begin
          cycle_phase_on_next = !cycle_phase_on;
          cycle_start_next    = req.now_ms;
        end
        per_rule = cycle_phase_on_next;
      end

      if (cfg.periodic_enable && cfg.ignore_low_voltage)
        relay_state_next = per_rule;
      else if (cfg.cutoff_enable && cfg.periodic_enable)
        relay_state_next = cut_rule && per_rule;
      else if (cfg.cutoff_enable)
        relay_state_next = cut_rule;
      else if (cfg.periodic_enable)
        relay_state_next = per_rule;
    end
  end

  assign rsp.relay_on         = relay_state_next;
  assign rsp.override_active  = override_flag_next;
  assign rsp.event_code       = ev;
  assign rsp.event_millivolts = ev_mv;

  always_ff @(posedge clk) begin
    if (rst) begin
      relay_state     <= 1'b0;
      override_flag   <= 1'b0;
      override_length <= 32'd0;
      override_start  <= 32'd0;
      pending_valid   <= 1'b0;
      pending_target  <= 1'b0;
      debounce_start  <= 32'd0;
      cycle_started   <= 1'b0;
      cycle_phase_on  <= 1'b0;
      cycle_start     <= 32'd0;
    end else if (go) begin
      relay_state     <= relay_state_next;
      override_flag   <= override_flag_next;
      override_length <= override_length_next;
      override_start  <= override_start_next;
      pending_valid   <= pending_valid_next;
      pending_target  <= pending_target_next;
      debounce_start  <= debounce_start_next;
      cycle_started   <= cycle_started_next;
      cycle_phase_on  <= cycle_phase_on_next;
      cycle_start     <= cycle_start_next;
    end
  end

endmodule

FILE: rtl/relay_voltage_cutoff_periodic_control_top.sv
// ----------------------------------------------------------------------------
// relay_voltage_cutoff_periodic_control_top
// Relay controller: voltage window cutoff, periodic cycle, manual override.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req) carries one command item: an
//   update with time and voltage, a manual set, or an override release.
//   rsp channel (rsp_valid/rsp_stall/rsp) returns exactly one result item
//   per request: relay state, override flag and any event raised.
//   An accepted item is taken into the input register, is processed and
//   lands in the result register, from which the result is offered. One
//   item per cycle is sustained while rsp_stall holds no result; the state
//   update is a single pass of compares and 32-bit subtractions between
//   the two registers.
//   While rsp_stall holds a result, the input register still takes one item;
//   after that req_stall rises until the result is taken.
//   Configuration (cfg_we/cfg_index/cfg_data) must be written while idle; the block does not enforce it.
//   Synchronous reset empties both registers, returns the relay to off,
//   clears the override and all timers, and loads the register defaults.
// ----------------------------------------------------------------------------
module relay_voltage_cutoff_periodic_control_top import rvc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  req_t                    req,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  output rsp_t                    rsp,
  input  logic                    cfg_we,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data
);

  cfg_t cfg;
  req_t s1_item;
  logic s1_valid;
  rsp_t eng_rsp;
  logic out_free;
  logic advance;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign advance   = s1_valid && out_free;
  assign req_stall = s1_valid && !out_free;

  rvc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rvc_engine u_engine (
    .clk (clk),
    .rst (rst),
    .go  (advance),
    .req (s1_item),
    .cfg (cfg),
    .rsp (eng_rsp)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) s1_item <= req;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) rsp <= eng_rsp;
  end

`ifndef SYNTH
  a_evmv_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.event_code == EV_NONE || rsp.event_code == EV_EXPIRED)
      |-> rsp.event_millivolts == 16'd0)
    else $error("event millivolts set without a voltage event");

  a_expired_clears: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.event_code == EV_EXPIRED |-> !rsp.override_active)
    else $error("override still active after expiry event");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid && rsp_valid && rsp_stall)
    else $error("input stalled without a blocked result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && !s1_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule
